// ===== rtl/pds_pkg.sv =====
`timescale 1ns / 1ps

package pds_pkg;

    // Coordinate width of a stored point; the point ports carry 11 bits and the
    // squared distances 23 bits, so this is fixed with them.
    localparam int COORD_BITS = 11;

endpackage

// ===== rtl/pds_ram.sv =====
`timescale 1ns / 1ps

module pds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pds_datapath.sv =====
`timescale 1ns / 1ps

module pds_datapath #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [10:0]                   point_x,
    input  logic [10:0]                   point_y,
    input  logic                          pt_we,
    input  logic                          ovf_set,
    input  logic                          set_clear,
    input  logic [$clog2(MAX_POINTS)-1:0] pt_raddr,
    input  logic                          dist_we,
    input  logic [$clog2(MAX_POINTS*(MAX_POINTS-1)/2)-1:0] dist_waddr,
    input  logic [$clog2(MAX_POINTS*(MAX_POINTS-1)/2)-1:0] dist_raddr,
    input  logic                          a_cap,
    input  logic                          b_cap,
    input  logic                          sq_en,
    input  logic                          sum_en,
    input  logic                          stat_first,
    input  logic                          stat_en,
    input  logic                          cmp_en,
    input  logic                          dup_clr,
    output logic [$clog2(MAX_POINTS+1)-1:0] n_pts,
    output logic                          ovf,
    output logic [22:0]                   mn,
    output logic [22:0]                   mx,
    output logic                          dup_found
);

    localparam int COORD_BITS = pds_pkg::COORD_BITS;
    localparam int PAIRS = MAX_POINTS * (MAX_POINTS - 1) / 2;
    localparam int PW = $clog2(MAX_POINTS);
    localparam int DW = 2 * COORD_BITS + 1;

    logic [2*COORD_BITS-1:0] pt_rdata;
    logic [COORD_BITS-1:0]   ax_reg, ay_reg;
    logic [COORD_BITS-1:0]   dx_reg, dy_reg;
    logic [2*COORD_BITS-1:0] sqx_reg, sqy_reg;
    logic [22:0]             sum_reg;
    logic [22:0]             dist_rdata;
    logic [DW-1:0]           sum_full;
    logic [$clog2(MAX_POINTS+1)-1:0] n_reg;
    logic                    ovf_reg;
    logic [22:0]             mn_reg, mx_reg;
    logic                    dup_reg;

    pds_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_POINTS)) u_pts (
        .clk   (clk),
        .we    (pt_we),
        .waddr (n_reg[PW-1:0]),
        .wdata ({point_y[COORD_BITS-1:0], point_x[COORD_BITS-1:0]}),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    pds_ram #(.WIDTH(23), .DEPTH(PAIRS)) u_dist (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (sum_reg),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // Point count and overflow flag of the current set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (set_clear)
        begin
            n_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (pt_we)
            begin
                n_reg <= n_reg + 1'b1;
            end
            if (ovf_set)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    assign sum_full = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Distance pipeline: absolute differences, squares, sum.
    always_ff @(posedge clk)
    begin
        if (a_cap)
        begin
            ax_reg <= pt_rdata[COORD_BITS-1:0];
            ay_reg <= pt_rdata[2*COORD_BITS-1:COORD_BITS];
        end
        if (b_cap)
        begin
            dx_reg <= (ax_reg > pt_rdata[COORD_BITS-1:0]) ?
                      ax_reg - pt_rdata[COORD_BITS-1:0] :
                      pt_rdata[COORD_BITS-1:0] - ax_reg;
            dy_reg <= (ay_reg > pt_rdata[2*COORD_BITS-1:COORD_BITS]) ?
                      ay_reg - pt_rdata[2*COORD_BITS-1:COORD_BITS] :
                      pt_rdata[2*COORD_BITS-1:COORD_BITS] - ay_reg;
        end
        if (sq_en)
        begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
        end
        if (sum_en)
        begin
            sum_reg <= 23'(sum_full);
        end
    end

    // Minimum, maximum and duplicate search.
    always_ff @(posedge clk)
    begin
        if (stat_en)
        begin
            if (stat_first || sum_reg < mn_reg)
            begin
                mn_reg <= sum_reg;
            end
            if (stat_first || sum_reg > mx_reg)
            begin
                mx_reg <= sum_reg;
            end
        end
        if (dup_clr)
        begin
            dup_reg <= (sum_reg == 23'd0);
        end
        else if (cmp_en && dist_rdata == sum_reg)
        begin
            dup_reg <= 1'b1;
        end
    end

    assign n_pts     = n_reg;
    assign ovf       = ovf_reg;
    assign mn        = mn_reg;
    assign mx        = mx_reg;
    assign dup_found = dup_reg;

endmodule

// ===== rtl/pds_ctrl.sv =====
`timescale 1ns / 1ps

module pds_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          last_point,
    input  logic [$clog2(MAX_POINTS+1)-1:0] n_pts,
    input  logic                          ovf,
    input  logic [22:0]                   mn,
    input  logic [22:0]                   mx,
    input  logic                          dup_found,
    output logic                          busy,
    output logic                          pt_we,
    output logic                          ovf_set,
    output logic                          set_clear,
    output logic [$clog2(MAX_POINTS)-1:0] pt_raddr,
    output logic                          dist_we,
    output logic [$clog2(MAX_POINTS*(MAX_POINTS-1)/2)-1:0] dist_waddr,
    output logic [$clog2(MAX_POINTS*(MAX_POINTS-1)/2)-1:0] dist_raddr,
    output logic                          a_cap,
    output logic                          b_cap,
    output logic                          sq_en,
    output logic                          sum_en,
    output logic                          stat_first,
    output logic                          stat_en,
    output logic                          cmp_en,
    output logic                          dup_clr,
    output logic                          done,
    output logic [22:0]                   min_dist_sq,
    output logic [22:0]                   max_dist_sq,
    output logic [10:0]                   pair_count,
    output logic [10:0]                   distinct_count,
    output logic                          empty_set,
    output logic                          overflow
);

    localparam int PAIRS = MAX_POINTS * (MAX_POINTS - 1) / 2;
    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int QW = $clog2(PAIRS + 1);
    localparam int AW = $clog2(PAIRS);

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_WA, S_RDB, S_WB, S_DIFF, S_SQ, S_SUM,
        S_SCAN, S_SCANW, S_STORE, S_DONE
    } state_t;

    state_t          state_reg;
    logic [PW-1:0]   i_reg, j_reg;
    logic [QW-1:0]   pairs_reg, scan_reg;
    logic [QW-1:0]   dist_reg;
    logic            accept;
    logic            stored;

    assign accept = start && !busy;
    assign stored = (n_pts < CW'(MAX_POINTS));

    assign pt_we   = accept && stored;
    assign ovf_set = accept && !stored;
    assign busy    = (state_reg != S_IDLE);

    // Point reads: point i on the first read, point j on the second.
    assign pt_raddr   = (state_reg == S_RDA) ? i_reg : j_reg;
    assign a_cap      = (state_reg == S_WA);
    assign b_cap      = (state_reg == S_WB);
    assign sq_en      = (state_reg == S_DIFF);
    assign sum_en     = (state_reg == S_SQ);
    assign stat_en    = (state_reg == S_SUM);
    assign stat_first = (pairs_reg == '0);
    assign dup_clr    = (state_reg == S_SUM);
    assign dist_raddr = AW'(scan_reg);
    assign cmp_en     = (state_reg == S_SCANW);
    assign dist_we    = (state_reg == S_STORE);
    assign dist_waddr = AW'(pairs_reg);
    assign set_clear  = (state_reg == S_DONE);

    // Sequencer over pairs i < j; each new distance is compared with all
    // earlier ones to count distinct nonzero values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            pairs_reg      <= '0;
            scan_reg       <= '0;
            dist_reg       <= '0;
            done           <= 1'b0;
            min_dist_sq    <= '0;
            max_dist_sq    <= '0;
            pair_count     <= '0;
            distinct_count <= '0;
            empty_set      <= 1'b0;
            overflow       <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && last_point)
                    begin
                        i_reg     <= '0;
                        j_reg     <= PW'(1);
                        pairs_reg <= '0;
                        dist_reg  <= '0;
                        if ((n_pts + CW'(pt_we)) < CW'(2))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_RDA;
                        end
                    end
                end
                S_RDA:   state_reg <= S_WA;
                S_WA:    state_reg <= S_RDB;
                S_RDB:   state_reg <= S_WB;
                S_WB:    state_reg <= S_DIFF;
                S_DIFF:  state_reg <= S_SQ;
                S_SQ:    state_reg <= S_SUM;
                S_SUM:
                begin
                    scan_reg  <= '0;
                    state_reg <= (pairs_reg == '0) ? S_STORE : S_SCAN;
                end
                S_SCAN:  state_reg <= S_SCANW;
                S_SCANW:
                begin
                    if (scan_reg + 1'b1 == pairs_reg)
                    begin
                        state_reg <= S_STORE;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_STORE:
                begin
                    if (!dup_found)
                    begin
                        dist_reg <= dist_reg + 1'b1;
                    end
                    pairs_reg <= pairs_reg + 1'b1;
                    if (CW'(j_reg) + 1'b1 < n_pts)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RDA;
                    end
                    else if (CW'(i_reg) + CW'(2) < n_pts)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= i_reg + PW'(2);
                        state_reg <= S_RDA;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done           <= 1'b1;
                    empty_set      <= (pairs_reg == '0);
                    min_dist_sq    <= (pairs_reg == '0) ? 23'd0 : mn;
                    max_dist_sq    <= (pairs_reg == '0) ? 23'd0 : mx;
                    pair_count     <= 11'(pairs_reg);
                    distinct_count <= 11'(dist_reg);
                    overflow       <= ovf;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/pairwise_distance_stats.sv =====
`timescale 1ns / 1ps

// Channel   Transfer when        Ports
// point     start && !busy       point_x, point_y, last_point
// result    done (one cycle)     min_dist_sq, max_dist_sq, pair_count,
//                                distinct_count, empty_set, overflow
//
// After the marked last point, each pair i<j passes the distance pipeline
// (read point i, read point j, differences, squares, sum), then a compare
// against every earlier pair in the distance memory with its registered
// read port, and then the store. busy is high until the result strobe.
// Reset clears all control state; the memories hold no reset value. The
// receiver cannot stall the result.

module pairwise_distance_stats #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [10:0] point_x,
    input  logic [10:0] point_y,
    input  logic        last_point,
    output logic        done,
    output logic [22:0] min_dist_sq,
    output logic [22:0] max_dist_sq,
    output logic [10:0] pair_count,
    output logic [10:0] distinct_count,
    output logic        empty_set,
    output logic        overflow
);

    localparam int PAIRS = MAX_POINTS * (MAX_POINTS - 1) / 2;

    logic [$clog2(MAX_POINTS+1)-1:0] n_pts;
    logic                            ovf, pt_we, ovf_set, set_clear;
    logic [$clog2(MAX_POINTS)-1:0]   pt_raddr;
    logic                            dist_we;
    logic [$clog2(PAIRS)-1:0]        dist_waddr, dist_raddr;
    logic a_cap, b_cap, sq_en, sum_en, stat_first, stat_en, cmp_en, dup_clr;
    logic [22:0]                     mn, mx;
    logic                            dup_found;

    pds_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk (clk), .rst_n (rst_n), .start (start), .last_point (last_point),
        .n_pts (n_pts), .ovf (ovf), .mn (mn), .mx (mx),
        .dup_found (dup_found), .busy (busy), .pt_we (pt_we),
        .ovf_set (ovf_set), .set_clear (set_clear), .pt_raddr (pt_raddr),
        .dist_we (dist_we), .dist_waddr (dist_waddr),
        .dist_raddr (dist_raddr), .a_cap (a_cap), .b_cap (b_cap),
        .sq_en (sq_en), .sum_en (sum_en), .stat_first (stat_first),
        .stat_en (stat_en), .cmp_en (cmp_en), .dup_clr (dup_clr),
        .done (done), .min_dist_sq (min_dist_sq),
        .max_dist_sq (max_dist_sq), .pair_count (pair_count),
        .distinct_count (distinct_count), .empty_set (empty_set),
        .overflow (overflow)
    );

    pds_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk (clk), .rst_n (rst_n), .point_x (point_x), .point_y (point_y),
        .pt_we (pt_we), .ovf_set (ovf_set), .set_clear (set_clear),
        .pt_raddr (pt_raddr), .dist_we (dist_we), .dist_waddr (dist_waddr),
        .dist_raddr (dist_raddr), .a_cap (a_cap), .b_cap (b_cap),
        .sq_en (sq_en), .sum_en (sum_en), .stat_first (stat_first),
        .stat_en (stat_en), .cmp_en (cmp_en), .dup_clr (dup_clr),
        .n_pts (n_pts), .ovf (ovf), .mn (mn),
        .mx (mx), .dup_found (dup_found)
    );

endmodule

// ===== rtl/pds_checker.sv =====
`timescale 1ns / 1ps

module pds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        last_point,
    input logic        done,
    input logic [22:0] min_dist_sq,
    input logic [22:0] max_dist_sq,
    input logic [10:0] pair_count,
    input logic [10:0] distinct_count,
    input logic        empty_set
);

    // A result comes only at the end of a busy phase.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without busy phase");

    // The block is already free in the cycle of its result.
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy after result");

    // An unmarked point never makes the block busy.
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_point) |=> !busy)
        else $error("busy after unmarked point");

    // Ordering and counts of a result.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (min_dist_sq <= max_dist_sq && distinct_count <= pair_count))
        else $error("inconsistent result");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && empty_set) |-> (pair_count == 11'd0))
        else $error("empty set with pairs");

endmodule

bind pairwise_distance_stats pds_checker u_pds_checker (
    .clk (clk), .rst_n (rst_n), .start (start), .busy (busy),
    .last_point (last_point), .done (done), .min_dist_sq (min_dist_sq),
    .max_dist_sq (max_dist_sq), .pair_count (pair_count),
    .distinct_count (distinct_count), .empty_set (empty_set)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY         = 64;
    localparam int CYCLE_LIMIT      = 40000000;
    localparam int RANDOM_PER_PHASE = 130;

    typedef struct packed {
        logic [22:0] min_sq;
        logic [22:0] max_sq;
        logic [10:0] pairs;
        logic [10:0] distinct;
        logic        empty;
        logic        dropped;
    } pair_stats_t;

    // Models the point store and predicts the statistics of each finished set.
    class pair_stats_board;
        logic [10:0]  px [CAPACITY];
        logic [10:0]  py [CAPACITY];
        int           loaded;
        bit           dropped_seen;
        pair_stats_t  expected_q [$];
        int           errors;

        function new();
            loaded       = 0;
            dropped_seen = 0;
            errors       = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Note one accepted point transfer; a marked last point closes the set.
        function void note_point(logic [10:0] x, logic [10:0] y, logic last);
            int unsigned dist_q [$];
            int unsigned prev;
            int          dx;
            int          dy;
            pair_stats_t r;
            if (loaded < CAPACITY) begin
                px[loaded] = x;
                py[loaded] = y;
                loaded++;
            end
            else
                dropped_seen = 1;
            if (!last)
                return;
            for (int i = 0; i < loaded; i++)
                for (int j = i + 1; j < loaded; j++) begin
                    dx = int'(px[i]) - int'(px[j]);
                    dy = int'(py[i]) - int'(py[j]);
                    dist_q = {dist_q, int'(dx * dx + dy * dy)};
                end
            dist_q.sort();
            r = '0;
            r.pairs   = 11'(dist_q.size());
            r.empty   = (loaded < 2);
            r.dropped = dropped_seen;
            if (dist_q.size() > 0) begin
                r.min_sq = 23'(dist_q[0]);
                r.max_sq = 23'(dist_q[dist_q.size() - 1]);
                prev = 0;
                foreach (dist_q[k])
                    if (dist_q[k] != prev) begin
                        r.distinct = 11'(r.distinct + 1);
                        prev = dist_q[k];
                    end
            end
            expected_q = {expected_q, r};
            loaded       = 0;
            dropped_seen = 0;
        endfunction

        // Compare one result transfer with the oldest expectation.
        task check_result(pair_stats_t got);
            pair_stats_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            e = expected_q.pop_front();
            if (got.min_sq !== e.min_sq)
                report($sformatf("min_dist_sq %0d, expected %0d", got.min_sq, e.min_sq));
            if (got.max_sq !== e.max_sq)
                report($sformatf("max_dist_sq %0d, expected %0d", got.max_sq, e.max_sq));
            if (got.pairs !== e.pairs)
                report($sformatf("pair_count %0d, expected %0d", got.pairs, e.pairs));
            if (got.distinct !== e.distinct)
                report($sformatf("distinct_count %0d, expected %0d",
                                 got.distinct, e.distinct));
            if (got.empty !== e.empty)
                report($sformatf("empty_set %0b, expected %0b", got.empty, e.empty));
            if (got.dropped !== e.dropped)
                report($sformatf("overflow %0b, expected %0b", got.dropped, e.dropped));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [10:0] point_x;
    logic [10:0] point_y;
    logic        last_point;
    logic        done;
    logic [22:0] min_dist_sq;
    logic [22:0] max_dist_sq;
    logic [10:0] pair_count;
    logic [10:0] distinct_count;
    logic        empty_set;
    logic        overflow;

    pair_stats_board board;
    int              cycles;

    pairwise_distance_stats dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .point_x        (point_x),
        .point_y        (point_y),
        .last_point     (last_point),
        .done           (done),
        .min_dist_sq    (min_dist_sq),
        .max_dist_sq    (max_dist_sq),
        .pair_count     (pair_count),
        .distinct_count (distinct_count),
        .empty_set      (empty_set),
        .overflow       (overflow)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[pairwise_distance_stats] ERROR");
            $finish;
        end
    end

    // Observe point and result transfers at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                board.check_result({min_dist_sq, max_dist_sq, pair_count,
                                    distinct_count, empty_set, overflow});
            if (start && !busy)
                board.note_point(point_x, point_y, last_point);
        end
    end

    // Offer one point, idling first at random, and hold it until transferred.
    task send_point(logic [10:0] x, logic [10:0] y, logic last, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start = 0;
            @(negedge clk);
        end
        start      = 1;
        point_x    = x;
        point_y    = y;
        last_point = last;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function logic [10:0] pick_coord(bit narrow);
        if (narrow)
            return 11'($urandom_range(3));
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 11'd2047 : 11'd0;
        return 11'($urandom_range(2047));
    endfunction

    // One set of random points; narrow sets give duplicates and repeated distances.
    task send_random_set(int idle_pct, output int n);
        int sel;
        bit narrow;
        sel    = $urandom_range(99);
        n      = (sel < 85) ? $urandom_range(1, 8) :
                 (sel < 96) ? $urandom_range(9, 16) : $urandom_range(17, 24);
        narrow = ($urandom_range(2) == 0);
        for (int i = 0; i < n; i++)
            send_point(pick_coord(narrow), pick_coord(narrow), i == n - 1, idle_pct);
    endtask

    initial
    begin
        int idle_pct;
        int sent;
        int n;
        board      = new();
        cycles     = 0;
        rst_n      = 0;
        start      = 0;
        point_x    = '0;
        point_y    = '0;
        last_point = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: a lone point, extreme coordinates, duplicates.
        send_point(11'd100, 11'd200, 1, 0);
        send_point(11'd0, 11'd0, 0, 0);
        send_point(11'd2047, 11'd2047, 1, 0);
        send_point(11'd5, 11'd5, 0, 0);
        send_point(11'd5, 11'd5, 1, 0);
        send_point(11'd2047, 11'd0, 0, 0);
        send_point(11'd0, 11'd2047, 0, 0);
        send_point(11'd2047, 11'd2047, 0, 0);
        send_point(11'd0, 11'd0, 1, 0);
        send_point(11'd1, 11'd1, 0, 0);
        send_point(11'd1, 11'd1, 0, 0);
        send_point(11'd2, 11'd2, 0, 0);
        send_point(11'd1, 11'd1, 1, 0);

        // Directed: a full store, then a further marked last point that is dropped.
        for (int i = 0; i < CAPACITY; i++)
            send_point(11'($urandom_range(2047)), 11'($urandom_range(2047)), 0, 0);
        send_point(11'd2047, 11'd2047, 1, 0);

        // Random sets over several idling phases.
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 51 : (phase == 3) ? 22 : 0;
            while (sent < (phase + 1) * RANDOM_PER_PHASE) begin
                send_random_set(idle_pct, n);
                sent = sent + n;
            end
        end
        start = 0;

        // Drain outstanding results, then allow the pipeline to settle.
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("[pairwise_distance_stats] OK");
        else
            $display("[pairwise_distance_stats] ERROR");
        $finish;
    end

endmodule

// ===== pairwise_distance_stats.f =====
rtl/pds_pkg.sv
rtl/pds_ram.sv
rtl/pds_datapath.sv
rtl/pds_ctrl.sv
rtl/pairwise_distance_stats.sv
rtl/pds_checker.sv
tb/tb_top.sv
